### sv/ftnap_pkg.sv
package ftnap_pkg;

	localparam int MAX_LEN = 256;
	localparam int POS_W   = $clog2(MAX_LEN + 1);

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic        valid_res;
		logic [15:0] zone;
		logic [15:0] net;
		logic [15:0] node;
		logic [15:0] point;
		logic        has_point;
		logic        has_domain;
		logic [7:0]  domain_start;
		logic [7:0]  domain_length;
	} res_t;

	function automatic logic is_ws(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
			c == 8'h0C || c == 8'h0D;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

endpackage

### sv/ftnap_in_if.sv
interface ftnap_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       is_last;

	modport source (output valid, output text_byte, output is_last, input ready);
	modport sink (input valid, input text_byte, input is_last, output ready);
endinterface

### sv/ftnap_out_if.sv
interface ftnap_out_if;
	logic        valid;
	logic        ready;
	logic        valid_res;
	logic [15:0] zone;
	logic [15:0] net;
	logic [15:0] node;
	logic [15:0] point;
	logic        has_point;
	logic        has_domain;
	logic [7:0]  domain_start;
	logic [7:0]  domain_length;

	modport source (output valid, output valid_res, output zone, output net, output node,
		output point, output has_point, output has_domain, output domain_start,
		output domain_length, input ready);
	modport sink (input valid, input valid_res, input zone, input net, input node,
		input point, input has_point, input has_domain, input domain_start,
		input domain_length, output ready);
endinterface

### sv/ftnap_core.sv
module ftnap_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         c,
	input  logic               last,
	output ftnap_pkg::res_t    res
);

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_ZONE,
		PH_NET,
		PH_NODE,
		PH_POINT,
		PH_DOMAIN,
		PH_TRAIL
	} phase_t;

	phase_t                        phase_q, n_phase;
	logic [31:0]                   acc_q, n_acc;
	logic                          ovf_q, n_ovf;
	logic                          seen_q, n_seen;
	logic                          failed_q, n_failed;
	logic [15:0]                   zone_q, n_zone;
	logic [15:0]                   net_q, n_net;
	logic [15:0]                   node_q, n_node;
	logic [15:0]                   point_q, n_point;
	logic                          pp_q, n_pp;
	logic                          dp_q, n_dp;
	logic [ftnap_pkg::POS_W-1:0]   pos_q, n_pos;
	logic [7:0]                    doff_q, n_doff;
	logic [7:0]                    dend_q, n_dend;

	logic        dig, ws, close_ok;
	logic [35:0] prod;

	logic        f_failed, f_pp;
	logic [15:0] f_node, f_point;

	assign dig      = ftnap_pkg::is_digit(c);
	assign ws       = ftnap_pkg::is_ws(c);
	assign close_ok = seen_q && !ovf_q;
	// acc * 10 as two shifted copies, plus the digit value.
	assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, c[3:0]};

	always_comb begin
		n_phase  = phase_q;
		n_acc    = acc_q;
		n_ovf    = ovf_q;
		n_seen   = seen_q;
		n_failed = failed_q;
		n_zone   = zone_q;
		n_net    = net_q;
		n_node   = node_q;
		n_point  = point_q;
		n_pp     = pp_q;
		n_dp     = dp_q;
		n_pos    = pos_q;
		n_doff   = doff_q;
		n_dend   = dend_q;

		if (pos_q >= ftnap_pkg::POS_W'(ftnap_pkg::MAX_LEN)) begin
			n_failed = 1'b1;
		end else begin
			n_pos = pos_q + 1'b1;
		end

		if (!n_failed) begin
			unique case (phase_q)
				PH_LEAD: begin
					if (ws) begin
						n_phase = PH_LEAD;
					end else if (dig) begin
						n_acc   = prod[31:0];
						n_ovf   = ovf_q | (|prod[35:32]);
						n_seen  = 1'b1;
						n_phase = PH_ZONE;
					end else begin
						n_failed = 1'b1;
					end
				end
				PH_ZONE, PH_NET: begin
					if (dig) begin
						n_acc  = prod[31:0];
						n_ovf  = ovf_q | (|prod[35:32]);
						n_seen = 1'b1;
					end else if (close_ok && ((phase_q == PH_ZONE && c == ftnap_pkg::CH_COLON) ||
						(phase_q == PH_NET && c == ftnap_pkg::CH_SLASH))) begin
						if (phase_q == PH_ZONE) begin
							n_zone  = acc_q[15:0];
							n_phase = PH_NET;
						end else begin
							n_net   = acc_q[15:0];
							n_phase = PH_NODE;
						end
						n_acc  = '0;
						n_seen = 1'b0;
						n_ovf  = 1'b0;
					end else begin
						n_failed = 1'b1;
					end
				end
				PH_NODE, PH_POINT: begin
					if (dig) begin
						n_acc  = prod[31:0];
						n_ovf  = ovf_q | (|prod[35:32]);
						n_seen = 1'b1;
					end else if ((c == ftnap_pkg::CH_DOT && phase_q == PH_NODE) ||
						c == ftnap_pkg::CH_AT || ws) begin
						if (!close_ok) begin
							n_failed = 1'b1;
						end else begin
							if (phase_q == PH_NODE) begin
								n_node = acc_q[15:0];
							end else begin
								n_point = acc_q[15:0];
								n_pp    = 1'b1;
							end
							n_acc  = '0;
							n_seen = 1'b0;
							n_ovf  = 1'b0;
							if (c == ftnap_pkg::CH_AT) begin
								n_dp    = 1'b1;
								n_doff  = 8'(n_pos);
								n_dend  = 8'(n_pos);
								n_phase = PH_DOMAIN;
							end else if (ws) begin
								n_phase = PH_TRAIL;
							end else begin
								// The dot ends the node number and opens the point.
								n_phase = PH_POINT;
							end
						end
					end else begin
						n_failed = 1'b1;
					end
				end
				PH_DOMAIN: begin
					if (!ws) begin
						n_dend = 8'(n_pos);
					end
				end
				PH_TRAIL: begin
					if (!ws) begin
						n_failed = 1'b1;
					end
				end
				default: begin
					n_failed = 1'b1;
				end
			endcase
		end
	end

	// Close whatever number is still open when the text ends.
	always_comb begin
		f_failed = n_failed;
		f_node   = n_node;
		f_point  = n_point;
		f_pp     = n_pp;
		if (!n_failed) begin
			if (n_phase == PH_NODE) begin
				if (n_seen && !n_ovf) begin
					f_node = n_acc[15:0];
				end else begin
					f_failed = 1'b1;
				end
			end else if (n_phase == PH_POINT) begin
				if (n_seen && !n_ovf) begin
					f_point = n_acc[15:0];
					f_pp    = 1'b1;
				end else begin
					f_failed = 1'b1;
				end
			end else if (n_phase != PH_DOMAIN && n_phase != PH_TRAIL) begin
				f_failed = 1'b1;
			end
		end
	end

	always_comb begin
		res = '0;
		if (!f_failed) begin
			res.valid_res  = 1'b1;
			res.zone       = n_zone;
			res.net        = n_net;
			res.node       = f_node;
			res.point      = f_pp ? f_point : 16'd0;
			res.has_point  = f_pp;
			res.has_domain = n_dp;
			if (n_dp) begin
				res.domain_start  = n_doff;
				res.domain_length = n_dend - n_doff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEAD;
			acc_q    <= '0;
			ovf_q    <= 1'b0;
			seen_q   <= 1'b0;
			failed_q <= 1'b0;
			zone_q   <= '0;
			net_q    <= '0;
			node_q   <= '0;
			point_q  <= '0;
			pp_q     <= 1'b0;
			dp_q     <= 1'b0;
			pos_q    <= '0;
			doff_q   <= '0;
			dend_q   <= '0;
		end else if (take) begin
			if (last) begin
				phase_q  <= PH_LEAD;
				acc_q    <= '0;
				ovf_q    <= 1'b0;
				seen_q   <= 1'b0;
				failed_q <= 1'b0;
				zone_q   <= '0;
				net_q    <= '0;
				node_q   <= '0;
				point_q  <= '0;
				pp_q     <= 1'b0;
				dp_q     <= 1'b0;
				pos_q    <= '0;
				doff_q   <= '0;
				dend_q   <= '0;
			end else begin
				phase_q  <= n_phase;
				acc_q    <= n_acc;
				ovf_q    <= n_ovf;
				seen_q   <= n_seen;
				failed_q <= n_failed;
				zone_q   <= n_zone;
				net_q    <= n_net;
				node_q   <= n_node;
				point_q  <= n_point;
				pp_q     <= n_pp;
				dp_q     <= n_dp;
				pos_q    <= n_pos;
				doff_q   <= n_doff;
				dend_q   <= n_dend;
			end
		end
	end

endmodule

### sv/ftn_address_parser_top.sv
// Throughput: one text byte per cycle, sustained, while results are taken.
// Flow: a byte is registered in byte_s1 on acceptance and parsed from there; the verdict for
// the last byte is then registered in res_q, and that byte waits while an old verdict is untaken.
// The parse step (character class, multiply-by-ten accumulate, phase update) is combinational.
// Reset (arst_n low, asynchronous) empties both registers and returns the parser to its
// leading-whitespace state with all counts and values cleared.
module ftn_address_parser_top (
	input  logic         clk,
	input  logic         arst_n,
	ftnap_in_if.sink     text,
	ftnap_out_if.source  verdict
);

	logic                v_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;
	logic                ov_q;
	ftnap_pkg::res_t     res_q;
	ftnap_pkg::res_t     res;
	logic                adv;

	// A byte that produces no verdict never waits on the output side.
	assign adv        = v_s1 && (!last_s1 || !ov_q || verdict.ready);
	assign text.ready = !v_s1 || adv;

	ftnap_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (adv),
		.c      (byte_s1),
		.last   (last_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.text_byte;
			last_s1 <= text.is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (adv && last_s1) begin
			ov_q <= 1'b1;
		end else if (verdict.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			res_q <= res;
		end
	end

	assign verdict.valid         = ov_q;
	assign verdict.valid_res     = res_q.valid_res;
	assign verdict.zone          = res_q.zone;
	assign verdict.net           = res_q.net;
	assign verdict.node          = res_q.node;
	assign verdict.point         = res_q.point;
	assign verdict.has_point     = res_q.has_point;
	assign verdict.has_domain    = res_q.has_domain;
	assign verdict.domain_start  = res_q.domain_start;
	assign verdict.domain_length = res_q.domain_length;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!ov_q |-> text.ready)
		else $error("input stalled while the result register is empty");

	a_verdict_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> ov_q)
		else $error("last byte parsed but no verdict registered");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !res_q.valid_res) |-> (res_q.zone == 16'd0 && res_q.net == 16'd0 &&
		res_q.node == 16'd0 && !res_q.has_point && !res_q.has_domain))
		else $error("invalid verdict carries nonzero fields");

	a_no_point: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !res_q.has_point) |-> res_q.point == 16'd0)
		else $error("point value reported without a point");

	a_no_domain: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !res_q.has_domain) |-> (res_q.domain_start == 8'd0 &&
		res_q.domain_length == 8'd0))
		else $error("domain span reported without a domain");

endmodule

### tb/ftn_address_parser_top_tb.sv
module ftn_address_parser_top_tb;

	localparam int CLK_PERIOD = 12;
	localparam int RESET_CYCLES = 11;
	localparam int TEXT_BYTES = 1050;
	localparam int LIMIT_CYCLES = 100000;
	localparam logic [7:0] WS_SET [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

	typedef enum logic [2:0] {
		ST_LEAD, ST_ZONE, ST_NET, ST_NODE, ST_POINT, ST_DOMAIN, ST_TRAIL
	} parse_state_e;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} text_item_t;

	typedef logic [7:0] text_t[$];

	logic clk = 1'b0;
	logic arst_n;

	ftnap_in_if  text();
	ftnap_out_if verdict();

	ftn_address_parser_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text),
		.verdict(verdict)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	text_item_t         byte_q[$];
	ftnap_pkg::res_t    verdict_q[$];
	int                 mismatch_cnt = 0;

	// Parser state mirrored for prediction.
	parse_state_e pstate = ST_LEAD;
	logic [31:0]  acc = '0;
	logic         acc_ovf = 1'b0;
	logic         got_digit = 1'b0;
	logic         bad = 1'b0;
	logic [15:0]  zone_v = '0;
	logic [15:0]  net_v = '0;
	logic [15:0]  node_v = '0;
	logic [15:0]  point_v = '0;
	logic         pt_seen = 1'b0;
	logic         dom_seen = 1'b0;
	int           byte_cnt = 0;
	logic [7:0]   dom_off = '0;
	logic [7:0]   dom_end = '0;

	function automatic logic is_blank(input logic [7:0] c);
		foreach (WS_SET[i]) begin
			if (c == WS_SET[i]) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic is_num_char(input logic [7:0] c);
		return c >= ftnap_pkg::CH_ZERO && c <= ftnap_pkg::CH_NINE;
	endfunction

	function automatic void take_digit(input logic [7:0] c);
		logic [35:0] wide;
		wide = {4'b0, acc} * 36'd10 + 36'(c - ftnap_pkg::CH_ZERO);
		if (wide[35:32] != 4'd0) begin
			acc_ovf = 1'b1;
		end
		acc = wide[31:0];
		got_digit = 1'b1;
	endfunction

	// Closes the running number; a missing number or one past 32 bits spoils the text, else its low 16 bits are kept.
	function automatic logic close_num(inout logic [15:0] val);
		if (!got_digit || acc_ovf) begin
			bad = 1'b1;
			return 1'b0;
		end
		val = acc[15:0];
		acc = '0;
		got_digit = 1'b0;
		acc_ovf = 1'b0;
		return 1'b1;
	endfunction

	task automatic parse_byte(input logic [7:0] c, input logic last);
		logic ok;
		ftnap_pkg::res_t v;
		if (byte_cnt >= ftnap_pkg::MAX_LEN) begin
			bad = 1'b1;
		end else begin
			byte_cnt++;
		end
		if (!bad) begin
			case (pstate)
				ST_LEAD: begin
					if (!is_blank(c)) begin
						if (is_num_char(c)) begin
							take_digit(c);
							pstate = ST_ZONE;
						end else begin
							bad = 1'b1;
						end
					end
				end
				ST_ZONE: begin
					if (is_num_char(c)) begin
						take_digit(c);
					end else if (c == ftnap_pkg::CH_COLON && close_num(zone_v)) begin
						pstate = ST_NET;
					end else begin
						bad = 1'b1;
					end
				end
				ST_NET: begin
					if (is_num_char(c)) begin
						take_digit(c);
					end else if (c == ftnap_pkg::CH_SLASH && close_num(net_v)) begin
						pstate = ST_NODE;
					end else begin
						bad = 1'b1;
					end
				end
				ST_NODE, ST_POINT: begin
					if (is_num_char(c)) begin
						take_digit(c);
					end else if (c == ftnap_pkg::CH_DOT && pstate == ST_NODE) begin
						if (close_num(node_v)) begin
							pstate = ST_POINT;
						end
					end else if (c == ftnap_pkg::CH_AT || is_blank(c)) begin
						ok = (pstate == ST_NODE) ? close_num(node_v) : close_num(point_v);
						if (ok) begin
							if (pstate == ST_POINT) begin
								pt_seen = 1'b1;
							end
							if (c == ftnap_pkg::CH_AT) begin
								dom_seen = 1'b1;
								dom_off = 8'(byte_cnt);
								dom_end = 8'(byte_cnt);
								pstate = ST_DOMAIN;
							end else begin
								pstate = ST_TRAIL;
							end
						end
					end else begin
						bad = 1'b1;
					end
				end
				ST_DOMAIN: begin
					if (!is_blank(c)) begin
						dom_end = 8'(byte_cnt);
					end
				end
				ST_TRAIL: begin
					if (!is_blank(c)) begin
						bad = 1'b1;
					end
				end
				default: bad = 1'b1;
			endcase
		end
		if (last) begin
			if (!bad) begin
				if (pstate == ST_NODE) begin
					ok = close_num(node_v);
				end else if (pstate == ST_POINT) begin
					if (close_num(point_v)) begin
						pt_seen = 1'b1;
					end
				end else if (pstate != ST_DOMAIN && pstate != ST_TRAIL) begin
					bad = 1'b1;
				end
			end
			v = '0;
			if (!bad) begin
				v.valid_res = 1'b1;
				v.zone = zone_v;
				v.net = net_v;
				v.node = node_v;
				v.point = pt_seen ? point_v : 16'd0;
				v.has_point = pt_seen;
				v.has_domain = dom_seen;
				if (dom_seen) begin
					v.domain_start = dom_off;
					v.domain_length = dom_end - dom_off;
				end
			end
			verdict_q.push_back(v);
			pstate = ST_LEAD;
			acc = '0;
			acc_ovf = 1'b0;
			got_digit = 1'b0;
			bad = 1'b0;
			zone_v = '0;
			net_v = '0;
			node_v = '0;
			point_v = '0;
			pt_seen = 1'b0;
			dom_seen = 1'b0;
			byte_cnt = 0;
			dom_off = '0;
			dom_end = '0;
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("[%0t] verdict mismatch: %s", $time, msg);
		mismatch_cnt++;
	endtask

	task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
		end
	endtask

	// Idle cycles before the next transaction, with occasional stretches of none.
	function automatic int draw_wait(inout int calm);
		if (calm != 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 4);
	endfunction

	function automatic logic [7:0] ws_char();
		return WS_SET[$urandom_range(0, 5)];
	endfunction

	function automatic text_t str_text(input string s);
		text_t t;
		for (int i = 0; i < s.len(); i++) begin
			t.push_back(s[i]);
		end
		return t;
	endfunction

	function automatic string num_text();
		longint unsigned v;
		string s;
		s = "";
		case ($urandom_range(0, 11))
			0, 1, 2, 3, 4, 5: v = $urandom_range(0, 999);
			6: v = $urandom_range(60000, 70000);
			7: v = 64'hFFFF_FFFF;
			8: v = 64'h1_0000_0000 + $urandom_range(0, 100000);
			9: v = $urandom();
			10: return {"00", $sformatf("%0d", $urandom_range(0, 65535))};
			default: begin
				repeat ($urandom_range(11, 14)) begin
					s = {s, $sformatf("%0d", $urandom_range(0, 9))};
				end
				return s;
			end
		endcase
		return $sformatf("%0d", v);
	endfunction

	// Address in zone:net/node form, whose numbers may overflow; with bare_at it stops right after the at sign.
	function automatic text_t make_address(input bit padded, input bit bare_at);
		text_t t;
		if (padded) begin
			repeat ($urandom_range(0, 2)) t.push_back(ws_char());
		end
		t = {t, str_text(num_text())};
		t.push_back(ftnap_pkg::CH_COLON);
		t = {t, str_text(num_text())};
		t.push_back(ftnap_pkg::CH_SLASH);
		t = {t, str_text(num_text())};
		if (bare_at) begin
			t.push_back(ftnap_pkg::CH_AT);
			return t;
		end
		if ($urandom_range(0, 1) == 1) begin
			t.push_back(ftnap_pkg::CH_DOT);
			t = {t, str_text(num_text())};
		end
		if ($urandom_range(0, 2) == 0) begin
			t.push_back(ftnap_pkg::CH_AT);
			repeat ($urandom_range(0, 6)) begin
				t.push_back(($urandom_range(0, 4) == 0) ? ws_char() :
					8'($urandom_range(8'h21, 8'hFF)));
			end
		end
		if (padded) begin
			repeat ($urandom_range(0, 2)) t.push_back(ws_char());
		end
		return t;
	endfunction

	task automatic send_text(input text_t t);
		for (int i = 0; i < t.size(); i++) begin
			byte_q.push_back('{data: t[i], last: (i == t.size() - 1)});
		end
	endtask

	// Byte driver.
	text_item_t next_item;
	int         byte_gap = 0;
	int         send_calm = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text.valid <= 1'b0;
			text.text_byte <= '0;
			text.is_last <= 1'b0;
			byte_gap <= 0;
		end else begin
			if (text.valid && text.ready) begin
				parse_byte(text.text_byte, text.is_last);
			end
			if (!text.valid || text.ready) begin
				if (byte_gap != 0) begin
					text.valid <= 1'b0;
					byte_gap <= byte_gap - 1;
				end else if (byte_q.size() != 0) begin
					next_item = byte_q.pop_front();
					text.valid <= 1'b1;
					text.text_byte <= next_item.data;
					text.is_last <= next_item.last;
					byte_gap <= draw_wait(send_calm);
				end else begin
					text.valid <= 1'b0;
				end
			end
		end
	end

	// Verdict monitor.
	ftnap_pkg::res_t want;
	int              stall_left = 0;
	int              take_calm = 0;
	int              hold;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict.ready <= 1'b0;
			stall_left <= 0;
		end else if (verdict.valid && verdict.ready) begin
			if (verdict_q.size() == 0) begin
				report_mismatch("verdict transaction with none outstanding");
			end else begin
				want = verdict_q.pop_front();
				cmp_field("valid_res", 32'(verdict.valid_res), 32'(want.valid_res));
				cmp_field("zone", 32'(verdict.zone), 32'(want.zone));
				cmp_field("net", 32'(verdict.net), 32'(want.net));
				cmp_field("node", 32'(verdict.node), 32'(want.node));
				cmp_field("point", 32'(verdict.point), 32'(want.point));
				cmp_field("has_point", 32'(verdict.has_point), 32'(want.has_point));
				cmp_field("has_domain", 32'(verdict.has_domain), 32'(want.has_domain));
				cmp_field("domain_start", 32'(verdict.domain_start),
					32'(want.domain_start));
				cmp_field("domain_length", 32'(verdict.domain_length),
					32'(want.domain_length));
			end
			hold = draw_wait(take_calm);
			verdict.ready <= (hold == 0);
			stall_left <= hold;
		end else if (stall_left != 0) begin
			verdict.ready <= (stall_left == 1);
			stall_left <= stall_left - 1;
		end else begin
			verdict.ready <= 1'b1;
		end
	end

	initial begin
		text_t t;
		text_t core;
		int    n;
		int    idx;
		arst_n = 1'b0;
		text.valid = 1'b0;
		text.text_byte = '0;
		text.is_last = 1'b0;
		verdict.ready = 1'b0;

		// Directed: minimal and full forms, lone extreme bytes, blank text,
		// and whitespace inside the address.
		send_text(str_text("0:0/0"));
		send_text(str_text("9:8/7.6@Z\t"));
		send_text({8'h00});
		send_text({8'hFF});
		send_text({WS_SET[0]});
		send_text(str_text("1:2/3 4"));

		n = 0;
		while (byte_q.size() < TEXT_BYTES) begin
			if (n == 2) begin
				// Exactly MAX_LEN bytes with the at sign last: the domain offset wraps to 0.
				core = make_address(1'b0, 1'b1);
				t = {};
				repeat (ftnap_pkg::MAX_LEN - core.size()) t.push_back(ws_char());
				send_text({t, core});
			end else if (n == 9) begin
				// One byte over the length limit.
				core = make_address(1'b0, 1'b0);
				t = {};
				repeat (ftnap_pkg::MAX_LEN + 1 - core.size()) t.push_back(ws_char());
				send_text({t, core});
			end else begin
				idx = $urandom_range(0, 99);
				if (idx < 65) begin
					send_text(make_address(1'b1, 1'b0));
				end else if (idx < 82) begin
					t = make_address(1'b1, 1'b0);
					case ($urandom_range(0, 2))
						0: begin
							idx = $urandom_range(0, t.size() - 1);
							case ($urandom_range(0, 6))
								0: t[idx] = ftnap_pkg::CH_COLON;
								1: t[idx] = ftnap_pkg::CH_SLASH;
								2: t[idx] = ftnap_pkg::CH_DOT;
								3: t[idx] = ftnap_pkg::CH_AT;
								4: t[idx] = ws_char();
								5: t[idx] = ftnap_pkg::CH_ZERO + 8'($urandom_range(0, 9));
								default: t[idx] = 8'($urandom_range(0, 255));
							endcase
						end
						1: t = t[0:$urandom_range(0, t.size() - 2)];
						default: t.insert($urandom_range(1, t.size() - 1), ws_char());
					endcase
					send_text(t);
				end else if (idx < 94) begin
					t = {};
					repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(0, 255)));
					send_text(t);
				end else begin
					t = {};
					repeat ($urandom_range(1, 3)) t.push_back(ws_char());
					send_text(t);
				end
			end
			n++;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_q.size() != 0 || text.valid || verdict_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
